/* rtl/send_backlog_admit_and_batch_core_defines.svh */
// Assertion macros for the transmit queue manager datapath.
`ifndef SEND_BACKLOG_ADMIT_AND_BATCH_CORE_DEFINES_SVH
`define SEND_BACKLOG_ADMIT_AND_BATCH_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbab_pkg.sv */
// Types and constants shared by the transmit queue manager modules.
package sbab_pkg;

    localparam int OP_W        = 2;
    localparam int TAG_W       = 16;
    localparam int BYTES_W     = 16;
    localparam int SENT_W      = 24;
    localparam int BACKLOG_W   = 24;
    localparam int COUNT_CAP_W = 7;
    localparam int BATCH_LIM_W = 5;
    localparam int STATUS_W    = 3;
    localparam int REG_IDX_W   = 3;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    // Request operations.
    localparam logic [OP_W-1:0] OP_ENQUEUE    = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETION = 2'd1;
    localparam logic [OP_W-1:0] OP_CONNECT    = 2'd2;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HARD_DROP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SOFT_DROP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_CONN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DISCONN   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BATCH     = 3'd6;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_HARD_BYTE_CAP     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HARD_COUNT_CAP    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SOFT_BYTE_CAP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SOFT_COUNT_CAP    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BATCH_BYTE_LIMIT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BATCH_COUNT_LIMIT = 3'd5;

    typedef struct packed {
        logic [BACKLOG_W-1:0]   hard_byte_cap;
        logic [COUNT_CAP_W-1:0] hard_count_cap;
        logic [BACKLOG_W-1:0]   soft_byte_cap;
        logic [COUNT_CAP_W-1:0] soft_count_cap;
        logic [BACKLOG_W-1:0]   batch_byte_limit;
        logic [BATCH_LIM_W-1:0] batch_count_limit;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic                load_status;
        logic [STATUS_W-1:0] status_code;
        logic                last;
        logic                enq_write;
        logic                set_inflight;
        logic                clr_inflight;
        logic                set_link;
        logic                clr_link;
        logic                batch_start;
        logic                pop;
        logic                emit_pend;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            link_up;
        logic            inflight;
        logic            hard_drop;
        logic            soft_full;
        logic            sent_zero;
        logic            count_zero;
        logic            take;
        logic            pend_valid;
        logic            out_free;
    } dp_status_t;

endpackage

/* rtl/sbab_regs.sv */
// APB configuration register file for the transmit queue manager.
module sbab_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbab_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbab_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbab_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output sbab_pkg::cfg_t                  cfg
);
    import sbab_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hard_byte_cap     <= 24'd1048576;
            cfg_reg.hard_count_cap    <= 7'd64;
            cfg_reg.soft_byte_cap     <= 24'd262144;
            cfg_reg.soft_count_cap    <= 7'd32;
            cfg_reg.batch_byte_limit  <= 24'd65536;
            cfg_reg.batch_count_limit <= 5'd16;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HARD_BYTE_CAP:     cfg_reg.hard_byte_cap     <= pwdata[BACKLOG_W-1:0];
                REG_HARD_COUNT_CAP:    cfg_reg.hard_count_cap    <= pwdata[COUNT_CAP_W-1:0];
                REG_SOFT_BYTE_CAP:     cfg_reg.soft_byte_cap     <= pwdata[BACKLOG_W-1:0];
                REG_SOFT_COUNT_CAP:    cfg_reg.soft_count_cap    <= pwdata[COUNT_CAP_W-1:0];
                REG_BATCH_BYTE_LIMIT:  cfg_reg.batch_byte_limit  <= pwdata[BACKLOG_W-1:0];
                REG_BATCH_COUNT_LIMIT: cfg_reg.batch_count_limit <= pwdata[BATCH_LIM_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HARD_BYTE_CAP:     prdata = APB_DATA_W'(cfg_reg.hard_byte_cap);
            REG_HARD_COUNT_CAP:    prdata = APB_DATA_W'(cfg_reg.hard_count_cap);
            REG_SOFT_BYTE_CAP:     prdata = APB_DATA_W'(cfg_reg.soft_byte_cap);
            REG_SOFT_COUNT_CAP:    prdata = APB_DATA_W'(cfg_reg.soft_count_cap);
            REG_BATCH_BYTE_LIMIT:  prdata = APB_DATA_W'(cfg_reg.batch_byte_limit);
            REG_BATCH_COUNT_LIMIT: prdata = APB_DATA_W'(cfg_reg.batch_count_limit);
            default:               prdata = '0;
        endcase
    end

endmodule

/* rtl/sbab_ctrl.sv */
// Controller state machine: admission decision and batch sequencing.
module sbab_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sbab_pkg::dp_status_t   st,
    output sbab_pkg::cmd_t         cmd
);
    import sbab_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_CHK  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // The status word goes out once the output register is free.
                if (st.out_free)
                begin
                    cmd.load_status = 1'b1;
                    case (st.op)
                        OP_ENQUEUE:
                        begin
                            if (!st.link_up)
                            begin
                                cmd.status_code = ST_NOT_CONN;
                            end
                            else if (st.hard_drop)
                            begin
                                cmd.status_code = ST_HARD_DROP;
                            end
                            else if (st.inflight && st.soft_full)
                            begin
                                cmd.status_code = ST_SOFT_DROP;
                            end
                            else
                            begin
                                cmd.enq_write = 1'b1;
                                if (st.inflight)
                                begin
                                    cmd.status_code = ST_ACCEPTED;
                                end
                                else
                                begin
                                    cmd.status_code  = ST_BATCH;
                                    cmd.set_inflight = 1'b1;
                                    cmd.batch_start  = 1'b1;
                                end
                            end
                        end
                        OP_COMPLETION:
                        begin
                            if (st.sent_zero)
                            begin
                                cmd.status_code = ST_DISCONN;
                                cmd.clr_link    = 1'b1;
                            end
                            else if (st.count_zero)
                            begin
                                cmd.status_code  = ST_IDLE;
                                cmd.clr_inflight = 1'b1;
                            end
                            else if (!st.link_up)
                            begin
                                cmd.status_code = ST_NOT_CONN;
                            end
                            else
                            begin
                                cmd.status_code  = ST_BATCH;
                                cmd.set_inflight = 1'b1;
                                cmd.batch_start  = 1'b1;
                            end
                        end
                        OP_CONNECT:
                        begin
                            cmd.status_code = ST_ACCEPTED;
                            cmd.set_link    = 1'b1;
                        end
                        default:
                        begin
                            cmd.status_code = ST_DISCONN;
                            cmd.clr_link    = 1'b1;
                        end
                    endcase
                    // A started batch always pops at least one entry.
                    cmd.last   = !cmd.batch_start;
                    state_next = cmd.batch_start ? S_RD : S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (st.take)
                begin
                    if (!st.pend_valid || st.out_free)
                    begin
                        cmd.pop       = 1'b1;
                        cmd.emit_pend = st.pend_valid;
                        cmd.last      = 1'b0;
                        state_next    = S_RD;
                    end
                end
                else if (st.out_free)
                begin
                    cmd.emit_pend = 1'b1;
                    cmd.last      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/sbab_dp.sv */
// Datapath: queue memory, backlog counters, admission compares and result register.
`include "send_backlog_admit_and_batch_core_defines.svh"

module sbab_dp
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int BATCH_MAX   = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  sbab_pkg::cfg_t                  cfg,
    input  sbab_pkg::cmd_t                  cmd,
    output sbab_pkg::dp_status_t            st,
    input  logic [sbab_pkg::OP_W-1:0]       operation,
    input  logic [sbab_pkg::TAG_W-1:0]      buffer_tag,
    input  logic [sbab_pkg::BYTES_W-1:0]    buffer_bytes,
    input  logic [sbab_pkg::SENT_W-1:0]     sent_bytes,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kind,
    output logic [sbab_pkg::STATUS_W-1:0]   status,
    output logic [sbab_pkg::TAG_W-1:0]      entry_tag,
    output logic [sbab_pkg::BYTES_W-1:0]    entry_bytes,
    output logic                            last
);
    import sbab_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = ((CW > COUNT_CAP_W) ? CW : COUNT_CAP_W) + 1;
    localparam int NW = $clog2(BATCH_MAX + 1);
    localparam int LW = (NW > BATCH_LIM_W) ? NW : BATCH_LIM_W;
    localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] BATCH_CAP = LW'(BATCH_MAX);

    // Queue storage.
    logic [TAG_W-1:0]   tag_mem  [QUEUE_DEPTH];
    logic [BYTES_W-1:0] size_mem [QUEUE_DEPTH];

    // Captured request.
    logic [OP_W-1:0]    op_reg;
    logic [TAG_W-1:0]   tag_in_reg;
    logic [BYTES_W-1:0] bytes_in_reg;
    logic               sent_zero_reg;

    // Queue and link state.
    logic [AW-1:0]        head_reg,     head_next;
    logic [CW-1:0]        count_reg,    count_next;
    logic [BACKLOG_W-1:0] backlog_reg,  backlog_next;
    logic                 inflight_reg, inflight_next;
    logic                 link_reg,     link_next;

    // Batch state.
    logic [TAG_W-1:0]     rd_tag_reg;
    logic [BYTES_W-1:0]   rd_bytes_reg;
    logic [NW-1:0]        n_reg,          n_next;
    logic [BACKLOG_W-1:0] total_reg,      total_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]     pend_tag_reg;
    logic [BYTES_W-1:0]   pend_bytes_reg;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [TAG_W-1:0]     entry_tag_reg;
    logic [BYTES_W-1:0]   entry_bytes_reg;
    logic                 last_reg;

    logic [KW-1:0]        count_ext;
    logic [BACKLOG_W:0]   enq_sum;
    logic [BACKLOG_W:0]   batch_sum;
    logic [CW:0]          tail_sum;
    logic [CW:0]          tail_wrap;
    logic [AW-1:0]        tail_idx;
    logic [AW-1:0]        head_inc;
    logic [LW-1:0]        lim;
    logic                 fits_bytes;
    logic                 under_count;
    logic                 take;
    logic                 out_free;

    assign count_ext = KW'(count_reg);
    assign enq_sum   = {1'b0, backlog_reg} + (BACKLOG_W + 1)'(bytes_in_reg);
    assign batch_sum = {1'b0, total_reg} + (BACKLOG_W + 1)'(rd_bytes_reg);

    assign tail_sum  = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= DEPTH_EXT) ? (tail_sum - DEPTH_EXT) : tail_sum;
    assign tail_idx  = tail_wrap[AW-1:0];
    assign head_inc  = (head_reg == HEAD_LAST) ? '0 : (head_reg + AW'(1));

    // A limit of zero behaves as one: the first entry never checks it.
    assign lim = (LW'(cfg.batch_count_limit) < BATCH_CAP) ?
                 LW'(cfg.batch_count_limit) : BATCH_CAP;
    assign fits_bytes  = (batch_sum <= {1'b0, cfg.batch_byte_limit});
    assign under_count = (LW'(n_reg) < lim);
    assign take = (count_reg != '0) && ((n_reg == '0) || (fits_bytes && under_count));

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        st            = '0;
        st.op         = op_reg;
        st.link_up    = link_reg;
        st.inflight   = inflight_reg;
        st.hard_drop  = (enq_sum > {1'b0, cfg.hard_byte_cap})
                     || ((count_ext + KW'(1)) > KW'(cfg.hard_count_cap))
                     || (count_ext >= KW'(QUEUE_DEPTH));
        st.soft_full  = (backlog_reg >= cfg.soft_byte_cap)
                     || (count_ext >= KW'(cfg.soft_count_cap));
        st.sent_zero  = sent_zero_reg;
        st.count_zero = (count_reg == '0);
        st.take       = take;
        st.pend_valid = pend_valid_reg;
        st.out_free   = out_free;
    end

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        backlog_next    = backlog_reg;
        inflight_next   = inflight_reg;
        link_next       = link_reg;
        n_next          = n_reg;
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.enq_write)
        begin
            count_next   = count_reg + CW'(1);
            backlog_next = enq_sum[BACKLOG_W-1:0];
        end

        if (cmd.pop)
        begin
            head_next       = head_inc;
            count_next      = count_reg - CW'(1);
            backlog_next    = (BACKLOG_W'(rd_bytes_reg) > backlog_reg) ?
                              '0 : (backlog_reg - BACKLOG_W'(rd_bytes_reg));
            n_next          = n_reg + NW'(1);
            total_next      = batch_sum[BACKLOG_W-1:0];
            pend_valid_next = 1'b1;
        end
        else if (cmd.emit_pend)
        begin
            pend_valid_next = 1'b0;
        end

        if (cmd.batch_start)
        begin
            n_next          = '0;
            total_next      = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.set_inflight)
        begin
            inflight_next = 1'b1;
        end
        else if (cmd.clr_inflight)
        begin
            inflight_next = 1'b0;
        end

        if (cmd.set_link)
        begin
            link_next = 1'b1;
        end
        else if (cmd.clr_link)
        begin
            link_next = 1'b0;
        end

        if (cmd.load_status || cmd.emit_pend)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            backlog_reg    <= '0;
            inflight_reg   <= 1'b0;
            link_reg       <= 1'b0;
            n_reg          <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            backlog_reg    <= backlog_next;
            inflight_reg   <= inflight_next;
            link_reg       <= link_next;
            n_reg          <= n_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Request capture, pending entry and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= operation;
            tag_in_reg    <= buffer_tag;
            bytes_in_reg  <= buffer_bytes;
            sent_zero_reg <= (sent_bytes == '0);
        end

        if (cmd.pop)
        begin
            pend_tag_reg   <= rd_tag_reg;
            pend_bytes_reg <= rd_bytes_reg;
        end

        if (cmd.load_status)
        begin
            kind_reg        <= KIND_STATUS;
            status_reg      <= cmd.status_code;
            entry_tag_reg   <= '0;
            entry_bytes_reg <= '0;
            last_reg        <= cmd.last;
        end
        else if (cmd.emit_pend)
        begin
            kind_reg        <= KIND_ENTRY;
            status_reg      <= ST_BATCH;
            entry_tag_reg   <= pend_tag_reg;
            entry_bytes_reg <= pend_bytes_reg;
            last_reg        <= cmd.last;
        end
    end

    // Queue memory: one write port at the tail, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (cmd.enq_write)
        begin
            tag_mem[tail_idx]  <= tag_in_reg;
            size_mem[tail_idx] <= bytes_in_reg;
        end
        rd_tag_reg   <= tag_mem[head_reg];
        rd_bytes_reg <= size_mem[head_reg];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign entry_tag   = entry_tag_reg;
    assign entry_bytes = entry_bytes_reg;
    assign last        = last_reg;

    `SBAB_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CW'(QUEUE_DEPTH),
        "queue count beyond depth")
    `SBAB_ASSERT_NOW(a_pop_nonempty, cmd.pop, count_reg != '0,
        "pop from an empty queue")
    `SBAB_ASSERT_NOW(a_no_overwrite, cmd.load_status || cmd.emit_pend,
        !(out_valid_reg && out_stall), "result register overwritten while stalled")
    `SBAB_ASSERT_NEXT(a_batch_bound, cmd.pop, n_reg <= NW'(BATCH_MAX),
        "batch exceeded its entry bound")

endmodule

/* rtl/send_backlog_admit_and_batch_core.sv */
// Top level of the per-connection transmit queue manager.
//
// Requests arrive on the input channel (in_valid / in_stall) as one word
// holding operation, buffer_tag, buffer_bytes and sent_bytes. Each request
// produces one status word on the output channel (out_valid / out_stall),
// followed, when a batch is started, by one batch entry word per entry
// popped from the queue; last marks the final word of each request.
// One request is handled at a time: in_stall is high from the cycle after
// acceptance until the request's final word enters the output register.
// A request is captured on acceptance; its status word is then loaded into
// the output register from the evaluate state once that register is free.
// A started batch adds, for each entry, a registered read of the queue
// memory and a compare against the batch limits, and one more read and
// compare close the batch.
// A stalled receiver holds the current word in the output register and
// the controller simply waits; nothing is lost or repeated.
// Reset empties the queue, clears the link and in-flight flags and loads
// the register defaults; the queue memory itself needs no clearing.
// Configuration is written over the APB port, register i at byte 4*i.
module send_backlog_admit_and_batch_core
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int BATCH_MAX   = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbab_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbab_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbab_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sbab_pkg::OP_W-1:0]       operation,
    input  logic [sbab_pkg::TAG_W-1:0]      buffer_tag,
    input  logic [sbab_pkg::BYTES_W-1:0]    buffer_bytes,
    input  logic [sbab_pkg::SENT_W-1:0]     sent_bytes,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kind,
    output logic [sbab_pkg::STATUS_W-1:0]   status,
    output logic [sbab_pkg::TAG_W-1:0]      entry_tag,
    output logic [sbab_pkg::BYTES_W-1:0]    entry_bytes,
    output logic                            last
);
    import sbab_pkg::*;

    cfg_t       cfg;
    cmd_t       cmd;
    dp_status_t st;

    // Configuration registers; the user must write them only while no request is in progress (not enforced here).
    sbab_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller decides admission and steps through each batch, one
    // queue entry per memory read; the look-ahead of one entry lets it flag
    // the final word of a batch as it goes out.
    sbab_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the queue memory, the counters, the compares against
    // the caps and limits, and the output register.
    sbab_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BATCH_MAX   (BATCH_MAX)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .st           (st),
        .operation    (operation),
        .buffer_tag   (buffer_tag),
        .buffer_bytes (buffer_bytes),
        .sent_bytes   (sent_bytes),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .status       (status),
        .entry_tag    (entry_tag),
        .entry_bytes  (entry_bytes),
        .last         (last)
    );

endmodule
